// ===== sv/wdc_pkg.sv =====
package wdc_pkg;

   localparam int Q_BITS = 16;
   localparam int RATIO_W = Q_BITS + 1;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [1:0] CODE_NO = 2'd0;
   localparam logic [1:0] CODE_YES = 2'd1;
   localparam logic [1:0] CODE_NODATA = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_TARGET_CLASS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CIRCULAR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DIAGONAL = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AGGREGATION = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_WIDTH = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_HEIGHT = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK,
      ST_CHKW,
      ST_SCALE_INIT,
      ST_WALK,
      ST_DRAIN,
      ST_DIV_START,
      ST_DIV,
      ST_AGG,
      ST_DONE
   } state_type;

endpackage

// ===== sv/window_density_connectivity.sv =====
// Multi-scale density and connectivity over a stored class grid.
// Input channel (req_*): one transfer is either a cell write or a cell query.
// A write is taken and stores the cell code in an on-chip memory if the cell lies inside the area;
// it gives no result. A query walks every window position of each radius from
// radius_min to radius_max, one memory read per cycle through a two-stage
// read pipeline, and gives exactly one result transfer on the rsp_* channel.
// Each window position is probed at its centre and at K neighbours, where
// K is 4 with diagonals and 2 without; the window walk through the
// single memory read port sets the query time. Per scale, two 17-step dividers
// run in parallel after the walk. A nodata or out-of-area query skips the walk.
// The block takes one item at a time; while a query result waits in the output
// register under rsp_stall, the next transfer is already accepted, and a
// finished query holds until the output register is free.
// The configuration port takes a write on any cycle with csr_we high; writes
// are meant only while the block is idle. Reset restores the register defaults
// and empties the result register; the cell memory is not cleared, and every
// cell of the area must be written before it is queried.
module window_density_connectivity #(
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int MAX_RADIUS = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [7:0]                     req_col,
   input  logic [7:0]                     req_row,
   input  logic [7:0]                     req_cell_class,
   input  logic                           req_cell_nodata,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_valid_res,
   output logic [wdc_pkg::RATIO_W-1:0]    rsp_density,
   output logic [wdc_pkg::RATIO_W-1:0]    rsp_connectivity,
   input  logic                           csr_we,
   input  logic [wdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wdc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wdc_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int AW = CW + RW;
   localparam int MAXCR = (CW > RW) ? CW : RW;
   localparam int PW = ((MAXCR > 9) ? MAXCR : 9) + 2;
   localparam int RADW = $clog2(MAX_RADIUS + 1);
   localparam int DW = RADW + 2;
   localparam int SW = 2 * DW + 2;
   localparam int CNTW = $clog2(4 * (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);

   // Configuration registers.
   logic [7:0] target_ff;
   logic       circular_ff;
   logic       diagonal_ff;
   logic [3:0] rmin_ff;
   logic [3:0] rmax_ff;
   logic       aggr_ff;
   logic [8:0] gw_ff;
   logic [8:0] gh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 8'd1;
         circular_ff <= 1'b1;
         diagonal_ff <= 1'b1;
         rmin_ff <= 4'd1;
         rmax_ff <= 4'd3;
         aggr_ff <= 1'b0;
         gw_ff <= 9'd256;
         gh_ff <= 9'd256;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_CLASS: target_ff <= csr_wdata[7:0];
            REG_CIRCULAR:     circular_ff <= csr_wdata[0];
            REG_DIAGONAL:     diagonal_ff <= csr_wdata[0];
            REG_RADIUS_MIN:   rmin_ff <= csr_wdata[3:0];
            REG_RADIUS_MAX:   rmax_ff <= csr_wdata[3:0];
            REG_AGGREGATION:  aggr_ff <= csr_wdata[0];
            REG_GRID_WIDTH:   gw_ff <= csr_wdata;
            REG_GRID_HEIGHT:  gh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [PW-1:0] aw, ah;
   logic [RADW-1:0] rlo, rhi;

   always_comb begin
      aw = (32'(gw_ff) < MAX_WIDTH) ? PW'(gw_ff) : PW'(MAX_WIDTH);
      ah = (32'(gh_ff) < MAX_HEIGHT) ? PW'(gh_ff) : PW'(MAX_HEIGHT);
      rlo = (32'(rmin_ff) < MAX_RADIUS) ? RADW'(rmin_ff) : RADW'(MAX_RADIUS);
      rhi = (32'(rmax_ff) < MAX_RADIUS) ? RADW'(rmax_ff) : RADW'(MAX_RADIUS);
   end

   state_type state_ff, state_in;

   logic [7:0]           x_ff, y_ff;
   logic [RADW-1:0]      r_ff;
   logic signed [DW-1:0] dx_ff, dy_ff;
   logic [2:0]           k_ff;
   logic                 first_ff;
   logic                 res_valid_ff;
   logic [RATIO_W-1:0]   acc_d_ff, acc_c_ff;

   logic               rsp_valid_ff;
   logic               rsp_valid_res_ff;
   logic [RATIO_W-1:0] rsp_density_ff, rsp_connectivity_ff;

   // Read pipeline: stage 1 issues the address, stage 2 sees the code.
   logic       p1_valid_ff, p1_ok_ff, p1_center_ff;
   logic [1:0] rd_ff;
   logic       v_ok_ff, v_yes_ff;
   logic [CNTW-1:0] n_all_ff, n_yes_ff, n_pair_ff, n_yy_ff;

   logic [1:0] mem [2**AW];

   // Control decode.
   logic issue, div_start, out_load, wr_en, accept, inside_req, last_probe;
   logic [2:0] kn;
   logic div_d_busy, div_c_busy;
   logic [RATIO_W-1:0] quot_d, quot_c;

   // Probe position of the current walk step.
   logic signed [DW-1:0] ox, oy, pdx, pdy;
   logic signed [SW-1:0] dd, rr;
   logic signed [PW-1:0] px, py;
   logic                 probe_ok;
   logic [AW-1:0]        rd_addr;
   logic signed [DW-1:0] rs;
   logic [1:0]           wr_code;
   logic                 w_ok, w_yes;

   assign accept = req_valid && !req_stall;
   assign kn = diagonal_ff ? 3'd4 : 3'd2;
   assign rs = DW'(r_ff);
   assign inside_req = ($signed(PW'(req_col)) < aw) && ($signed(PW'(req_row)) < ah);
   assign last_probe = (k_ff == kn) && (dx_ff == rs) && (dy_ff == rs);

   always_comb begin
      case (k_ff)
         3'd1:    begin ox = DW'(0); oy = DW'(1);  end
         3'd2:    begin ox = DW'(1); oy = DW'(0);  end
         3'd3:    begin ox = DW'(1); oy = DW'(1);  end
         3'd4:    begin ox = DW'(1); oy = -DW'(1); end
         default: begin ox = DW'(0); oy = DW'(0);  end
      endcase
      if (state_ff == ST_CHK) begin
         pdx = '0;
         pdy = '0;
      end else begin
         pdx = dx_ff + ox;
         pdy = dy_ff + oy;
      end
      dd = SW'(pdx * pdx) + SW'(pdy * pdy);
      rr = SW'(r_ff * r_ff) + SW'(r_ff);
      px = $signed(PW'(x_ff)) + PW'(pdx);
      py = $signed(PW'(y_ff)) + PW'(pdy);
      probe_ok = (!circular_ff || dd <= rr) && (px >= 0) && (py >= 0)
                 && (px < aw) && (py < ah);
      rd_addr = {py[RW-1:0], px[CW-1:0]};
      wr_code = req_cell_nodata ? CODE_NODATA
                : ((req_cell_class == target_ff) ? CODE_YES : CODE_NO);
      w_ok = p1_ok_ff && (rd_ff == CODE_NO || rd_ff == CODE_YES);
      w_yes = (rd_ff == CODE_YES);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_QUERY) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK:        state_in = ST_CHKW;
         ST_CHKW: begin
            if (!p1_ok_ff || !w_ok || rlo > rhi) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCALE_INIT;
            end
         end
         ST_SCALE_INIT: state_in = ST_WALK;
         ST_WALK: begin
            if (last_probe) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:      state_in = ST_DIV_START;
         ST_DIV_START:  state_in = ST_DIV;
         ST_DIV: begin
            if (!div_d_busy && !div_c_busy) begin
               state_in = ST_AGG;
            end
         end
         ST_AGG:        state_in = (r_ff == rhi) ? ST_DONE : ST_SCALE_INIT;
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_stall = 1'b1;
      issue = 1'b0;
      div_start = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_stall = 1'b0;
         ST_CHK:       issue = 1'b1;
         ST_WALK:      issue = 1'b1;
         ST_DIV_START: div_start = 1'b1;
         ST_DONE:      out_load = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
      wr_en = accept && req_command == CMD_WRITE && inside_req;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[{RW'(req_row), CW'(req_col)}] <= wr_code;
      end
      if (issue) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         n_all_ff <= '0;
         n_yes_ff <= '0;
         n_pair_ff <= '0;
         n_yy_ff <= '0;
      end else begin
         p1_valid_ff <= issue;
         if (state_ff == ST_SCALE_INIT) begin
            n_all_ff <= '0;
            n_yes_ff <= '0;
            n_pair_ff <= '0;
            n_yy_ff <= '0;
         end else if (p1_valid_ff && state_ff != ST_CHKW) begin
            if (p1_center_ff) begin
               if (w_ok) begin
                  n_all_ff <= n_all_ff + 1'b1;
                  n_yes_ff <= n_yes_ff + CNTW'(w_yes);
               end
            end else if (v_ok_ff && w_ok) begin
               n_pair_ff <= n_pair_ff + CNTW'(v_yes_ff || w_yes);
               n_yy_ff <= n_yy_ff + CNTW'(v_yes_ff && w_yes);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         p1_ok_ff <= probe_ok;
         p1_center_ff <= (k_ff == 3'd0);
      end
      if (p1_valid_ff && p1_center_ff) begin
         v_ok_ff <= w_ok;
         v_yes_ff <= w_yes;
      end
      if (accept) begin
         x_ff <= req_col;
         y_ff <= req_row;
         k_ff <= '0;
      end
      unique case (state_ff)
         ST_CHKW: begin
            r_ff <= rlo;
            first_ff <= 1'b1;
            acc_d_ff <= '0;
            acc_c_ff <= '0;
            res_valid_ff <= p1_ok_ff && w_ok;
         end
         ST_SCALE_INIT: begin
            dx_ff <= -rs;
            dy_ff <= -rs;
            k_ff <= '0;
         end
         ST_WALK: begin
            if (k_ff != kn) begin
               k_ff <= k_ff + 1'b1;
            end else begin
               k_ff <= '0;
               if (dx_ff != rs) begin
                  dx_ff <= dx_ff + 1'b1;
               end else begin
                  dx_ff <= -rs;
                  dy_ff <= dy_ff + 1'b1;
               end
            end
         end
         ST_AGG: begin
            first_ff <= 1'b0;
            r_ff <= r_ff + 1'b1;
            if (first_ff) begin
               acc_d_ff <= quot_d;
               acc_c_ff <= quot_c;
            end else if (aggr_ff) begin
               acc_d_ff <= RATIO_W'((34'(acc_d_ff) * 34'(quot_d)) >> Q_BITS);
               acc_c_ff <= RATIO_W'((34'(acc_c_ff) * 34'(quot_c)) >> Q_BITS);
            end else begin
               acc_d_ff <= RATIO_W'(((RATIO_W + 1)'(acc_d_ff) + quot_d) >> 1);
               acc_c_ff <= RATIO_W'(((RATIO_W + 1)'(acc_c_ff) + quot_c) >> 1);
            end
         end
         default: ;
      endcase
   end

   wdc_div #(.NW(CNTW)) u_div_d (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (n_yes_ff),
      .den   (n_all_ff),
      .busy  (div_d_busy),
      .quot  (quot_d)
   );

   wdc_div #(.NW(CNTW)) u_div_c (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (n_yy_ff),
      .den   (n_pair_ff),
      .busy  (div_c_busy),
      .quot  (quot_c)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_valid_res_ff <= res_valid_ff;
         rsp_density_ff <= res_valid_ff ? acc_d_ff : '0;
         rsp_connectivity_ff <= res_valid_ff ? acc_c_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_density = rsp_density_ff;
   assign rsp_connectivity = rsp_connectivity_ff;

   a_yes_le_all: assert property (@(posedge clock) disable iff (reset)
      n_yes_ff <= n_all_ff)
      else $error("yes count above valid cell count");

   a_yy_le_pair: assert property (@(posedge clock) disable iff (reset)
      n_yy_ff <= n_pair_ff)
      else $error("yes-yes pair count above pair count");

   a_p1_follows_issue: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> $past(issue))
      else $error("read data stage without an issued read");

   a_agg_div_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_AGG |-> (!div_d_busy && !div_c_busy))
      else $error("scales combined while a divider is busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !out_load)
      else $error("result register overwritten while a transfer waits");

endmodule

// ===== sv/wdc_div.sv =====
module wdc_div #(
   parameter int NW = 15
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NW-1:0]               num,
   input  logic [NW-1:0]               den,
   output logic                        busy,
   output logic [wdc_pkg::RATIO_W-1:0] quot
);
   import wdc_pkg::*;

   localparam int CNT_W = $clog2(RATIO_W + 1);

   logic             busy_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NW:0]      rem_ff;
   logic [NW-1:0]    den_ff;
   logic             zero_ff;
   logic [RATIO_W-1:0] q_ff;
   logic [NW:0]      trial;
   logic             first;

   // The first step compares the numerator itself; it is never above the
   // denominator, so the remainder stays below twice the denominator.
   assign first = (cnt_ff == CNT_W'(RATIO_W));
   assign trial = first ? rem_ff : {rem_ff[NW-1:0], 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff <= CNT_W'(RATIO_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {1'b0, num};
         den_ff <= den;
         zero_ff <= (den == '0);
         q_ff <= '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_ff <= trial - {1'b0, den_ff};
            q_ff <= {q_ff[RATIO_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            q_ff <= {q_ff[RATIO_W-2:0], 1'b0};
         end
      end
   end

   assign busy = busy_ff;
   assign quot = zero_ff ? '0 : q_ff;

endmodule
